@@ rtl/core/lgg_pkg.sv @@
`default_nettype none
package lgg_pkg;

   // fixed field widths
   localparam int CFG_DIM_W   = 7;
   localparam int GEN_W       = 16;
   localparam int COORD_W     = 16;
   localparam int MODE_W      = 2;
   localparam int ROW_IDX_W   = 6;
   localparam int ROW_CELLS_W = 64;
   localparam int ROW_LIMIT   = 1 << ROW_IDX_W;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 2 * COORD_W;
   localparam int RSP_DATA_W  = 72;

   // command codes carried in req_tuser
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PLACE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RUN   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

   // csr register indexes, byte address is index times four
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_GENS   = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic clear_grid;
      logic place_load;
      logic place_write;
      logic run_start;
      logic gen_step;
      logic rpt_read;
      logic rpt_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic place_ok;
      logic gens_zero;
      logic rpt_last;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

@@ rtl/core/lgg_csr.sv @@
`default_nettype none
module lgg_csr #(
   parameter int MAX_COLS = 64,
   parameter int DEPTH    = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [lgg_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [lgg_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [lgg_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                    csr_pready,
   output logic      [lgg_pkg::CFG_DIM_W-1:0]      cols_used,
   output logic      [lgg_pkg::CFG_DIM_W-1:0]      rows_used,
   output logic      [lgg_pkg::GEN_W-1:0]          gens
);
   import lgg_pkg::*;

   logic [CFG_DIM_W-1:0] width_ff, width_in;
   logic [CFG_DIM_W-1:0] height_ff, height_in;
   logic [GEN_W-1:0]     gens_ff, gens_in;
   logic                 wr_en;
   logic [1:0]           reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      gens_in   = gens_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_WIDTH:  width_in  = csr_pwdata[CFG_DIM_W-1:0];
            REG_HEIGHT: height_in = csr_pwdata[CFG_DIM_W-1:0];
            REG_GENS:   gens_in   = csr_pwdata[GEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_DIM_W'(64);
         height_ff <= CFG_DIM_W'(64);
         gens_ff   <= GEN_W'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         gens_ff   <= gens_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         REG_GENS:   csr_prdata = CSR_DATA_W'(gens_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // clamp to what the storage holds, zero counts as one
   always_comb begin
      if (width_ff == '0)
         cols_used = CFG_DIM_W'(1);
      else if (width_ff > CFG_DIM_W'(MAX_COLS))
         cols_used = CFG_DIM_W'(MAX_COLS);
      else
         cols_used = width_ff;
      if (height_ff == '0)
         rows_used = CFG_DIM_W'(1);
      else if (height_ff > CFG_DIM_W'(DEPTH))
         rows_used = CFG_DIM_W'(DEPTH);
      else
         rows_used = height_ff;
   end

   assign gens = gens_ff;

endmodule
`default_nettype wire

@@ rtl/core/lgg_datapath.sv @@
`default_nettype none
module lgg_datapath #(
   parameter int MAX_COLS = 64,
   parameter int DEPTH    = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lgg_pkg::cmd_type                    cmd,
   output lgg_pkg::sts_type                         sts,
   input  wire logic signed [lgg_pkg::COORD_W-1:0]  req_col,
   input  wire logic signed [lgg_pkg::COORD_W-1:0]  req_row,
   input  wire logic        [lgg_pkg::CFG_DIM_W-1:0] cols_used,
   input  wire logic        [lgg_pkg::CFG_DIM_W-1:0] rows_used,
   input  wire logic        [lgg_pkg::GEN_W-1:0]    gens,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic             [lgg_pkg::ROW_IDX_W-1:0]   rsp_row_index,
   output logic             [lgg_pkg::ROW_CELLS_W-1:0] rsp_row_cells,
   output logic                                     rsp_last_row
);
   import lgg_pkg::*;

   localparam int CW  = MAX_COLS;
   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CIW = (CW > 1) ? $clog2(CW) : 1;
   localparam int SW  = $clog2(DEPTH + 2);

   logic [CW-1:0]    mem [DEPTH];
   logic [CW-1:0]    mem_q_ff;
   logic             vld_q_ff;
   logic [DEPTH-1:0] valid_ff, valid_in;

   logic [SW-1:0]    step_ff, step_in;
   logic [GEN_W-1:0] gen_left_ff, gen_left_in;
   logic [CW-1:0]    up_ff, up_in, mid_ff, mid_in;
   logic [AW-1:0]    row_ff;
   logic [CIW-1:0]   col_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [ROW_IDX_W-1:0]   out_index_ff;
   logic [ROW_CELLS_W-1:0] out_cells_ff;
   logic                   out_last_ff;

   logic [CW-1:0] wm, raw_row, rd_row, dn, new_row, wr_data;
   logic [SW-1:0] h_s, step_m2;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          rd_en, wr_en;
   logic          pass_read, dn_live, pass_calc, pass_end;

   assign h_s     = SW'(rows_used);
   assign step_m2 = step_ff - SW'(2);

   // columns in use
   always_comb begin
      for (int c = 0; c < CW; c++)
         wm[c] = (CFG_DIM_W'(c) < cols_used);
   end

   // cells past the width stay stored until a run wipes them
   assign raw_row   = vld_q_ff ? mem_q_ff : '0;
   assign rd_row    = raw_row & wm;
   assign pass_read = (step_ff < h_s);
   assign dn_live   = (step_ff <= h_s);
   assign pass_calc = (step_ff >= SW'(2));
   assign pass_end  = (step_ff == h_s + SW'(1));
   assign dn        = dn_live ? rd_row : '0;

   // next state of one row from the three-row window
   always_comb begin
      logic [CW-1:0] upl, upr, midl, midr, dnl, dnr;
      logic [3:0]    nb;
      upl  = up_ff << 1;
      upr  = up_ff >> 1;
      midl = mid_ff << 1;
      midr = mid_ff >> 1;
      dnl  = dn << 1;
      dnr  = dn >> 1;
      for (int c = 0; c < CW; c++) begin
         nb = 4'(up_ff[c]) + 4'(upl[c]) + 4'(upr[c]) + 4'(midl[c]) + 4'(midr[c])
            + 4'(dn[c]) + 4'(dnl[c]) + 4'(dnr[c]);
         new_row[c] = wm[c] & ((nb == 4'd3) | (mid_ff[c] & (nb == 4'd2)));
      end
   end

   // memory port selection
   assign rd_en   = cmd.place_load | cmd.rpt_read | (cmd.gen_step & pass_read);
   assign rd_addr = cmd.place_load ? req_row[AW-1:0] : step_ff[AW-1:0];
   assign wr_en   = cmd.place_write | cmd.rpt_load | (cmd.gen_step & pass_calc);

   always_comb begin
      priority if (cmd.place_write) begin
         wr_addr = row_ff;
         wr_data = raw_row | (CW'(1) << col_ff);
      end else if (cmd.rpt_load) begin
         wr_addr = step_ff[AW-1:0];
         wr_data = rd_row;
      end else begin
         wr_addr = step_m2[AW-1:0];
         wr_data = new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
         vld_q_ff <= valid_ff[rd_addr];
      end
   end

   // row valid flags, a row never written reads as dead
   always_comb begin
      valid_in = valid_ff;
      priority if (cmd.clear_grid) begin
         valid_in = '0;
      end else if (cmd.run_start) begin
         for (int i = 0; i < DEPTH; i++)
            if (SW'(i) >= h_s)
               valid_in[i] = 1'b0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end else begin
      end
   end

   // counters and row window
   always_comb begin
      step_in     = step_ff;
      gen_left_in = gen_left_ff;
      up_in       = up_ff;
      mid_in      = mid_ff;
      priority if (cmd.run_start) begin
         step_in     = '0;
         gen_left_in = gens;
      end else if (cmd.gen_step) begin
         if (step_ff == '0) begin
            up_in  = '0;
            mid_in = '0;
         end else begin
            up_in  = mid_ff;
            mid_in = dn;
         end
         if (pass_end) begin
            step_in     = '0;
            gen_left_in = gen_left_ff - GEN_W'(1);
         end else begin
            step_in = step_ff + SW'(1);
         end
      end else if (cmd.rpt_load) begin
         step_in = step_ff + SW'(1);
      end else begin
      end
   end

   assign out_valid_in = cmd.rpt_load | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         step_ff      <= '0;
         gen_left_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         step_ff      <= step_in;
         gen_left_ff  <= gen_left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff  <= up_in;
      mid_ff <= mid_in;
      if (cmd.place_load) begin
         row_ff <= req_row[AW-1:0];
         col_ff <= req_col[CIW-1:0];
      end
      if (cmd.rpt_load) begin
         out_index_ff <= ROW_IDX_W'(step_ff[AW-1:0]);
         out_cells_ff <= ROW_CELLS_W'(rd_row);
         out_last_ff  <= sts.rpt_last;
      end
   end

   // status
   assign sts.place_ok  = ~req_col[COORD_W-1] & ~req_row[COORD_W-1]
                        & ($unsigned(req_col) < COORD_W'(cols_used))
                        & ($unsigned(req_row) < COORD_W'(rows_used));
   assign sts.gens_zero = (gen_left_ff == '0);
   assign sts.rpt_last  = (step_ff == h_s - SW'(1));
   assign sts.out_free  = ~out_valid_ff | rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_row_index = out_index_ff;
   assign rsp_row_cells = out_cells_ff;
   assign rsp_last_row  = out_last_ff;

endmodule
`default_nettype wire

@@ rtl/core/lgg_ctrl.sv @@
`default_nettype none
module lgg_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [lgg_pkg::MODE_W-1:0]  req_mode,
   output logic                             req_ready,
   input  wire lgg_pkg::sts_type            sts,
   output lgg_pkg::cmd_type                 cmd
);
   import lgg_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PLACE  = 3'd1;
   localparam logic [2:0] S_GEN    = 3'd2;
   localparam logic [2:0] S_RPT_RD = 3'd3;
   localparam logic [2:0] S_RPT_LD = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_mode)
                  MODE_CLEAR: cmd.clear_grid = 1'b1;
                  MODE_PLACE: begin
                     if (sts.place_ok) begin
                        cmd.place_load = 1'b1;
                        state_in       = S_PLACE;
                     end
                  end
                  MODE_RUN: begin
                     cmd.run_start = 1'b1;
                     state_in      = S_GEN;
                  end
                  default: ;
               endcase
            end
         end
         S_PLACE: begin
            cmd.place_write = 1'b1;
            state_in        = S_IDLE;
         end
         S_GEN: begin
            if (sts.gens_zero)
               state_in = S_RPT_RD;
            else
               cmd.gen_step = 1'b1;
         end
         S_RPT_RD: begin
            cmd.rpt_read = 1'b1;
            state_in     = S_RPT_LD;
         end
         S_RPT_LD: begin
            if (sts.out_free) begin
               cmd.rpt_load = 1'b1;
               state_in     = sts.rpt_last ? S_IDLE : S_RPT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_IDLE;
      else
         state_ff <= state_in;
   end

endmodule
`default_nettype wire

@@ rtl/core/life_grid_generations_unit.sv @@
// life grid generations unit: conway life on a bounded bit grid, no wrap at the edges
// req channel: one word per command, tuser carries the mode
//   mode 0 clears the grid, mode 1 marks one cell live (a coordinate
//   outside the grid in use is dropped), mode 3 does nothing,
//   mode 2 runs generation_count generations and reports the grid
// rsp channel: one word per row in use, row_index and row_cells in tdata,
//   tlast set on the final row; cells at or beyond the width read as zero
// a run computes G = generation_count generations over H = rows in use:
//   each generation streams the H rows once through a three-row window,
//   at most one memory read and one write per cycle
// the report then reads each row and writes it back masked, one row at a time;
//   the registered row memory read needs a read state ahead of each load state
// a stalled receiver holds the report, the grid is not touched meanwhile
// req_tready is high only between commands; a new command may be taken while
//   the last report word still waits in the output register
// csr port: width at 0x0, height at 0x4, generation count at 0x8, pready always high
// reset: all cells dead, width 64, height 64, one generation; the grid is cleared
//   through per-row valid flags, so no clearing pass is needed
`default_nettype none
module life_grid_generations_unit #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [lgg_pkg::REQ_DATA_W-1:0]    req_tdata,   // cell_col[15:0], cell_row[31:16]
   input  wire logic [lgg_pkg::MODE_W-1:0]        req_tuser,   // mode[1:0]
   // result channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [lgg_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // row_index[5:0], row_cells[69:6], zero
   output logic                                   rsp_tlast,   // last_row
   // configuration port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [lgg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [lgg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [lgg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);
   import lgg_pkg::*;

   // rows the storage holds: the row index field limits it
   localparam int DEPTH = (MAX_ROWS < ROW_LIMIT) ? MAX_ROWS : ROW_LIMIT;

   cmd_type cmd;
   sts_type sts;

   logic [CFG_DIM_W-1:0]   cols_used;
   logic [CFG_DIM_W-1:0]   rows_used;
   logic [GEN_W-1:0]       gens;
   logic [ROW_IDX_W-1:0]   row_index;
   logic [ROW_CELLS_W-1:0] row_cells;
   logic                   last_row;

   lgg_csr #(
      .MAX_COLS (MAX_COLS),
      .DEPTH    (DEPTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cols_used   (cols_used),
      .rows_used   (rows_used),
      .gens        (gens)
   );

   lgg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_mode  (req_tuser),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lgg_datapath #(
      .MAX_COLS (MAX_COLS),
      .DEPTH    (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_col       (req_tdata[COORD_W-1:0]),
      .req_row       (req_tdata[2*COORD_W-1:COORD_W]),
      .cols_used     (cols_used),
      .rows_used     (rows_used),
      .gens          (gens),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_row_index (row_index),
      .rsp_row_cells (row_cells),
      .rsp_last_row  (last_row)
   );

   // pack the result word, pad bits stay zero
   assign rsp_tdata = RSP_DATA_W'({row_cells, row_index});
   assign rsp_tlast = last_row;

endmodule
`default_nettype wire
